// ===== rtl/nnis_pkg.sv =====
// Shared types, constants and factor decoding for the nearest-neighbor image scaler.
`timescale 1ns / 1ps
`default_nettype none

package nnis_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_DIM  = 2048;
  localparam int DEF_MAX_UP   = 4;
  localparam int DEF_MAX_DOWN = 16;

  // Fixed field widths
  localparam int ADDR_W   = 26;
  localparam int PIX_W    = 8;
  localparam int FACT_W   = 5;
  localparam int DW_W     = 14;
  localparam int CFG_W    = 14;
  localparam int CFG_IDX_W = 3;
  // Common width for position compares, holds any dimension up to 8192
  localparam int CMP_W    = 14;

  // Job queue depth between front and back
  localparam int Q_DEPTH  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_WINDOW_X      = 3'd1,
    REG_WINDOW_Y      = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_WINDOW_HEIGHT = 3'd4,
    REG_DEST_WIDTH    = 3'd5,
    REG_X_FACTOR      = 3'd6,
    REG_Y_FACTOR      = 3'd7
  } cfg_reg_e;

  // Decoded scale factor: up = replicate n times, else keep every n-th
  typedef struct packed {
    logic              up;
    logic [FACT_W-1:0] n;
  } factor_t;

  // One kept pixel handed from front to back
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [PIX_W-1:0]  value;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic factor_t decode_factor(logic [FACT_W-1:0] raw, int max_up,
                                            int max_down);
    factor_t f;
    logic [FACT_W-1:0] k;
    if (raw[FACT_W-1]) begin
      k = FACT_W'(6'd32 - {1'b0, raw});
      if (int'(k) > max_down) k = FACT_W'(max_down);
      f.up = 1'b0;
    end else begin
      k = (raw == '0) ? FACT_W'(1) : raw;
      if (int'(k) > max_up) k = FACT_W'(max_up);
      f.up = 1'b1;
    end
    f.n = k;
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nnis_front.sv =====
// Front end: tracks source position, applies crop window and decimation, queues kept pixels.
`timescale 1ns / 1ps
`default_nettype none

module nnis_front import nnis_pkg::*; #(
  parameter int MAX_DIM  = DEF_MAX_DIM,
  parameter int MAX_UP   = DEF_MAX_UP,
  parameter int MAX_DOWN = DEF_MAX_DOWN
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire logic [PIX_W-1:0]  pixel_value,
  input  wire logic              frame_start,
  input  wire logic [11:0]       source_width,
  input  wire logic [10:0]       window_x,
  input  wire logic [10:0]       window_y,
  input  wire logic [11:0]       window_width,
  input  wire logic [11:0]       window_height,
  input  wire logic [DW_W-1:0]   dest_width,
  input  wire logic [FACT_W-1:0] x_factor,
  input  wire logic [FACT_W-1:0] y_factor,
  output logic                   push,
  output job_t                   push_job
);

  localparam int CW  = $clog2(MAX_DIM);
  localparam int PW  = (MAX_DOWN > 1) ? $clog2(MAX_DOWN) : 1;
  localparam int DCW = $clog2(MAX_DIM * MAX_UP) + 1;
  localparam int YSW = FACT_W + DW_W;

  logic [CW-1:0]     col_r, col_nxt, row_r, row_nxt;
  logic [PW-1:0]     cph_r, cph_nxt, rph_r, rph_nxt;
  logic [DCW-1:0]    dcol_r, dcol_nxt;
  logic [ADDR_W-1:0] drb_r, drb_nxt;

  factor_t           xf, yf;
  logic [CMP_W-1:0]  sw, colx, rowx, wx, wy;
  logic [CW-1:0]     col, row;
  logic [PW-1:0]     cph, rph;
  logic [DCW-1:0]    dcol;
  logic [ADDR_W-1:0] drb;
  logic              col_in, row_in, keep;
  logic [YSW-1:0]    ystep;

  always_comb begin
    xf = decode_factor(x_factor, MAX_UP, MAX_DOWN);
    yf = decode_factor(y_factor, MAX_UP, MAX_DOWN);

    sw = CMP_W'(source_width);
    if (sw == '0) sw = CMP_W'(1);
    if (sw > CMP_W'(MAX_DIM)) sw = CMP_W'(MAX_DIM);

    // Frame start restarts all counters before this pixel is classified
    col  = frame_start ? '0 : col_r;
    row  = frame_start ? '0 : row_r;
    cph  = frame_start ? '0 : cph_r;
    rph  = frame_start ? '0 : rph_r;
    dcol = frame_start ? '0 : dcol_r;
    drb  = frame_start ? '0 : drb_r;

    colx = CMP_W'(col);
    rowx = CMP_W'(row);
    wx   = CMP_W'(window_x);
    wy   = CMP_W'(window_y);
    col_in = (colx >= wx) && ((colx - wx) < CMP_W'(window_width));
    row_in = (rowx >= wy) && ((rowx - wy) < CMP_W'(window_height));

    keep = col_in && row_in && (xf.up || cph == '0) && (yf.up || rph == '0);
    push = in_acc && keep;
    push_job.base  = drb + ADDR_W'(dcol);
    push_job.value = pixel_value;

    ystep = YSW'(yf.n) * YSW'(dest_width);

    col_nxt  = col;
    row_nxt  = row;
    cph_nxt  = cph;
    rph_nxt  = rph;
    dcol_nxt = dcol;
    drb_nxt  = drb;

    if (col_in && row_in) begin
      if (xf.up) begin
        dcol_nxt = dcol + DCW'(xf.n);
      end else begin
        if (cph == '0) dcol_nxt = dcol + DCW'(1);
        cph_nxt = (CMP_W'(cph) + CMP_W'(1) >= CMP_W'(xf.n)) ? '0 : cph + PW'(1);
      end
    end

    // End of source line: wrap the column side, advance the destination row
    if (colx + CMP_W'(1) >= sw) begin
      col_nxt  = '0;
      cph_nxt  = '0;
      dcol_nxt = '0;
      if (row_in) begin
        if (yf.up) begin
          drb_nxt = drb + ADDR_W'(ystep);
        end else begin
          if (rph == '0) drb_nxt = drb + ADDR_W'(dest_width);
          rph_nxt = (CMP_W'(rph) + CMP_W'(1) >= CMP_W'(yf.n)) ? '0 : rph + PW'(1);
        end
      end
      if (rowx + CMP_W'(1) >= CMP_W'(MAX_DIM)) begin
        row_nxt = '0;
        rph_nxt = '0;
        drb_nxt = '0;
      end else begin
        row_nxt = row + CW'(1);
      end
    end else begin
      col_nxt = col + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cph_r  <= '0;
      rph_r  <= '0;
      dcol_r <= '0;
      drb_r  <= '0;
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cph_r  <= cph_nxt;
      rph_r  <= rph_nxt;
      dcol_r <= dcol_nxt;
      drb_r  <= drb_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nnis_queue.sv =====
// Short job queue that decouples the front end from the result generator.
`timescale 1ns / 1ps
`default_nettype none

module nnis_queue import nnis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output q_stat_t   stat
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  job_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    stat.empty = (cnt_r == '0);
    stat.full  = (cnt_r == CNT_W'(Q_DEPTH));
    head       = mem_r[rd_r];
    wr_nxt     = (wr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    rd_nxt     = (rd_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_nxt;
      if (pop)  rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("job queue underflow");

endmodule

`default_nettype wire

// ===== rtl/nnis_back.sv =====
// Back end: expands each queued pixel into its replicated results behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module nnis_back import nnis_pkg::*; #(
  parameter int MAX_UP   = DEF_MAX_UP,
  parameter int MAX_DOWN = DEF_MAX_DOWN
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [DW_W-1:0]   dest_width,
  input  wire logic [FACT_W-1:0] x_factor,
  input  wire logic [FACT_W-1:0] y_factor,
  input  wire job_t              head,
  input  wire q_stat_t           stat,
  output logic                   pop,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [ADDR_W-1:0]      res_addr,
  output logic [PIX_W-1:0]       res_value,
  output logic                   res_last
);

  localparam int AW = (MAX_UP > 1) ? $clog2(MAX_UP) : 1;

  factor_t           xf, yf;
  logic [AW-1:0]     nx_m1, ny_m1;
  logic              load, emit, cur_last, need_job;

  logic              job_v_r, job_v_nxt;
  logic [ADDR_W-1:0] row_addr_r, row_addr_nxt;
  logic [PIX_W-1:0]  val_r, val_nxt;
  logic [AW-1:0]     a_r, a_nxt, b_r, b_nxt;

  logic              out_v_r, out_v_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [PIX_W-1:0]  out_val_r;
  logic              out_last_r;

  always_comb begin
    xf = decode_factor(x_factor, MAX_UP, MAX_DOWN);
    yf = decode_factor(y_factor, MAX_UP, MAX_DOWN);
    nx_m1 = xf.up ? AW'(xf.n - FACT_W'(1)) : '0;
    ny_m1 = yf.up ? AW'(yf.n - FACT_W'(1)) : '0;

    load     = !out_v_r || res_ready;
    emit     = load && job_v_r;
    cur_last = (a_r == nx_m1) && (b_r == ny_m1);
    need_job = !job_v_r || (emit && cur_last);
    pop      = need_job && !stat.empty;

    out_v_nxt = emit ? 1'b1 : (load ? 1'b0 : out_v_r);

    job_v_nxt    = job_v_r;
    row_addr_nxt = row_addr_r;
    val_nxt      = val_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    if (pop) begin
      job_v_nxt    = 1'b1;
      row_addr_nxt = head.base;
      val_nxt      = head.value;
      a_nxt        = '0;
      b_nxt        = '0;
    end else if (emit && cur_last) begin
      job_v_nxt = 1'b0;
    end else if (emit) begin
      if (a_r == nx_m1) begin
        a_nxt        = '0;
        b_nxt        = b_r + AW'(1);
        row_addr_nxt = row_addr_r + ADDR_W'(dest_width);
      end else begin
        a_nxt = a_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_addr_r <= row_addr_nxt;
    val_r      <= val_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    if (emit) begin
      out_addr_r <= row_addr_r + ADDR_W'(a_r);
      out_val_r  <= val_r;
      out_last_r <= cur_last;
    end
  end

  assign res_valid = out_v_r;
  assign res_addr  = out_addr_r;
  assign res_value = out_val_r;
  assign res_last  = out_last_r;

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_v_r |-> (a_r <= nx_m1 && b_r <= ny_m1))
    else $error("replication counter out of range");

  a_last_frees_job: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cur_last && stat.empty) |=> !job_v_r)
    else $error("job still active after its last result");

endmodule

`default_nettype wire

// ===== rtl/nearest_neighbor_image_scaler.sv =====
// Top level: configuration registers, front end, job queue and result generator.
// A kept pixel passes the job queue, job register and output register before its first result shows.
// Throughput: one result per cycle from the back end while jobs are queued and out_tready is high;
//   an input transfer per cycle while the job queue has room. Each kept pixel yields x-count
//   times y-count results, one address each; dropped pixels yield none.
// Reset (rst_n, synchronous, active low): registers return to full 2048 frame, factor 1;
//   position counters, job queue and output register clear.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_image_scaler import nnis_pkg::*; #(
  parameter int MAX_DIM  = DEF_MAX_DIM,
  parameter int MAX_UP   = DEF_MAX_UP,
  parameter int MAX_DOWN = DEF_MAX_DOWN
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Source pixel stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] pixel_value
  input  wire logic                 in_tuser,   // [0] frame_start
  // Result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [39:0]               out_tdata,  // [25:0] dest_address, [33:26] out_value, zero pad
  output logic                      out_tlast,  // last result of one source pixel
  // Configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers, to be written only while the pipeline is idle; the block does not enforce this
  logic [11:0]       source_width_r;
  logic [10:0]       window_x_r;
  logic [10:0]       window_y_r;
  logic [11:0]       window_width_r;
  logic [11:0]       window_height_r;
  logic [DW_W-1:0]   dest_width_r;
  logic [FACT_W-1:0] x_factor_r;
  logic [FACT_W-1:0] y_factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_width_r  <= 12'd2048;
      window_x_r      <= '0;
      window_y_r      <= '0;
      window_width_r  <= 12'd2048;
      window_height_r <= 12'd2048;
      dest_width_r    <= 14'd2048;
      x_factor_r      <= 5'd1;
      y_factor_r      <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_SOURCE_WIDTH:  source_width_r  <= cfg_data[11:0];
        REG_WINDOW_X:      window_x_r      <= cfg_data[10:0];
        REG_WINDOW_Y:      window_y_r      <= cfg_data[10:0];
        REG_WINDOW_WIDTH:  window_width_r  <= cfg_data[11:0];
        REG_WINDOW_HEIGHT: window_height_r <= cfg_data[11:0];
        REG_DEST_WIDTH:    dest_width_r    <= cfg_data[DW_W-1:0];
        REG_X_FACTOR:      x_factor_r      <= cfg_data[FACT_W-1:0];
        REG_Y_FACTOR:      y_factor_r      <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end takes a pixel whenever the job queue has room
  logic    in_acc, push, pop;
  job_t    push_job, head;
  q_stat_t q_stat;

  assign in_tready = !q_stat.full;
  assign in_acc    = in_tvalid && in_tready;

  nnis_front #(
    .MAX_DIM  (MAX_DIM),
    .MAX_UP   (MAX_UP),
    .MAX_DOWN (MAX_DOWN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_acc        (in_acc),
    .pixel_value   (in_tdata),
    .frame_start   (in_tuser),
    .source_width  (source_width_r),
    .window_x      (window_x_r),
    .window_y      (window_y_r),
    .window_width  (window_width_r),
    .window_height (window_height_r),
    .dest_width    (dest_width_r),
    .x_factor      (x_factor_r),
    .y_factor      (y_factor_r),
    .push          (push),
    .push_job      (push_job)
  );

  // Hold kept pixels here so the front end keeps going while results drain
  nnis_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  logic [ADDR_W-1:0] res_addr;
  logic [PIX_W-1:0]  res_value;

  // Back end expands each job and drives the output register
  nnis_back #(
    .MAX_UP   (MAX_UP),
    .MAX_DOWN (MAX_DOWN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dest_width (dest_width_r),
    .x_factor   (x_factor_r),
    .y_factor   (y_factor_r),
    .head       (head),
    .stat       (q_stat),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_addr   (res_addr),
    .res_value  (res_value),
    .res_last   (out_tlast)
  );

  assign out_tdata = {6'd0, res_value, res_addr};

endmodule

`default_nettype wire

// ===== dv/nearest_neighbor_image_scaler_test.sv =====
// Self-checking testbench for the nearest-neighbor image scaler: directed and random pixel streams.
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler_test;
  import nnis_pkg::*;

  localparam int CLK_PERIOD = 12;

  // One destination write: where a kept pixel lands and with what value
  typedef struct packed {
    bit [ADDR_W-1:0] addr;
    bit [PIX_W-1:0]  value;
    bit              last;
  } pixel_write_t;

  // Mirror of the eight configuration registers, at their register widths
  typedef struct packed {
    bit [11:0] src_w;
    bit [10:0] win_x;
    bit [10:0] win_y;
    bit [11:0] win_w;
    bit [11:0] win_h;
    bit [13:0] dst_w;
    bit [4:0]  x_fac;
    bit [4:0]  y_fac;
  } scaler_setup_t;

  // Decoded factor: up = replicate n times, else keep every n-th
  typedef struct packed {
    bit       up;
    bit [4:0] n;
  } scale_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_SOURCE_WIDTH;
  logic [CFG_W-1:0]     cfg_data   = '0;

  nearest_neighbor_image_scaler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Register mirror, starting from the reset values
  scaler_setup_t setup = '{src_w: 12'd2048, win_x: 11'd0, win_y: 11'd0, win_w: 12'd2048,
                           win_h: 12'd2048, dst_w: 14'd2048, x_fac: 5'd1, y_fac: 5'd1};

  // Predicted position state; all of it starts clear, as after reset
  bit [10:0]       src_col   = '0;
  bit [10:0]       src_row   = '0;
  bit [3:0]        col_phase = '0;
  bit [3:0]        row_phase = '0;
  bit [12:0]       dest_col  = '0;
  bit [ADDR_W-1:0] row_base  = '0;

  // Writes predicted but not yet seen on the result stream, oldest first
  pixel_write_t expected_writes[$];

  int fail_count    = 0;
  int send_idle_pct = 0;   // chance in a hundred that the sender idles after a transfer
  int stall_pct     = 0;   // chance in a hundred that the receiver stalls a cycle
  int hold_req      = 0;   // long receiver hold-off, picked up by the receiver process
  int hold_left     = 0;

  function automatic scale_t decode_scale(input bit [4:0] raw);
    scale_t s;
    int     k;
    if (raw[4]) begin
      // negative: keep every k-th, k limited to the deepest decimation
      k = 32 - int'(raw);
      if (k > DEF_MAX_DOWN) k = DEF_MAX_DOWN;
      s.up = 1'b0;
    end else begin
      // zero counts as one, large counts saturate at the deepest replication
      k = (raw == 0) ? 1 : int'(raw);
      if (k > DEF_MAX_UP) k = DEF_MAX_UP;
      s.up = 1'b1;
    end
    s.n = 5'(k);
    return s;
  endfunction

  function automatic scaler_setup_t make_setup(input int sw, input int wx, input int wy,
                                               input int ww, input int wh, input int dw,
                                               input int xf, input int yf);
    scaler_setup_t s;
    s.src_w = 12'(sw);
    s.win_x = 11'(wx);
    s.win_y = 11'(wy);
    s.win_w = 12'(ww);
    s.win_h = 12'(wh);
    s.dst_w = 14'(dw);
    s.x_fac = 5'(xf);
    s.y_fac = 5'(yf);
    return s;
  endfunction

  // Advance the predicted state by one accepted source pixel and queue its writes
  task automatic scale_pixel(input bit [7:0] pix, input bit fs);
    scale_t       xs;
    scale_t       ys;
    int unsigned  sw;
    int unsigned  nx;
    int unsigned  ny;
    bit           col_in;
    bit           row_in;
    bit           keep;
    pixel_write_t w;
    xs = decode_scale(setup.x_fac);
    ys = decode_scale(setup.y_fac);
    sw = (setup.src_w == 0) ? 1 : setup.src_w;
    if (sw > DEF_MAX_DIM) sw = DEF_MAX_DIM;

    // Frame start: this pixel is column 0, row 0
    if (fs) begin
      src_col   = '0;
      src_row   = '0;
      col_phase = '0;
      row_phase = '0;
      dest_col  = '0;
      row_base  = '0;
    end

    col_in = (src_col >= setup.win_x) &&
             (int'(src_col) - int'(setup.win_x) < int'(setup.win_w));
    row_in = (src_row >= setup.win_y) &&
             (int'(src_row) - int'(setup.win_y) < int'(setup.win_h));

    if (col_in && row_in) begin
      keep = (xs.up || col_phase == 0) && (ys.up || row_phase == 0);
      if (keep) begin
        nx = xs.up ? xs.n : 1;
        ny = ys.up ? ys.n : 1;
        for (int unsigned b = 0; b < ny; b++) begin
          for (int unsigned a = 0; a < nx; a++) begin
            w.addr  = ADDR_W'(row_base + b * setup.dst_w + dest_col + a);
            w.value = pix;
            w.last  = (b == ny - 1) && (a == nx - 1);
            expected_writes.push_back(w);
          end
        end
      end
      if (xs.up) begin
        dest_col = dest_col + xs.n;
      end else begin
        if (col_phase == 0) dest_col = dest_col + 1;
        col_phase = (col_phase + 1 >= xs.n) ? 4'd0 : col_phase + 1;
      end
    end

    // End of source line: wrap the column, step the destination row
    if (src_col + 1 >= sw) begin
      src_col   = '0;
      col_phase = '0;
      dest_col  = '0;
      if (row_in) begin
        if (ys.up) begin
          row_base = row_base + ys.n * setup.dst_w;
        end else begin
          if (row_phase == 0) row_base = row_base + setup.dst_w;
          row_phase = (row_phase + 1 >= ys.n) ? 4'd0 : row_phase + 1;
        end
      end
      // Row counter overflow restarts the frame
      if (src_row + 1 >= DEF_MAX_DIM) begin
        src_row   = '0;
        row_phase = '0;
        row_base  = '0;
      end else begin
        src_row = src_row + 1;
      end
    end else begin
      src_col = src_col + 1;
    end
  endtask

  // Offer one pixel, hold it until the transfer, then maybe idle.
  // Leave tvalid high otherwise so back-to-back pixels need no second assignment.
  task automatic push_pixel(input bit [7:0] pix, input bit fs);
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    scale_pixel(pix, fs);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every predicted write, then let dropped pixels
  // still in the pipe clear out
  task automatic drain_writes();
    in_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Keep cfg_we high across back-to-back writes; the caller lowers it
  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH:  setup.src_w = 12'(val);
      REG_WINDOW_X:      setup.win_x = 11'(val);
      REG_WINDOW_Y:      setup.win_y = 11'(val);
      REG_WINDOW_WIDTH:  setup.win_w = 12'(val);
      REG_WINDOW_HEIGHT: setup.win_h = 12'(val);
      REG_DEST_WIDTH:    setup.dst_w = 14'(val);
      REG_X_FACTOR:      setup.x_fac = 5'(val);
      REG_Y_FACTOR:      setup.y_fac = 5'(val);
      default: ;
    endcase
  endtask

  // Reprogram all registers, only once the block has gone idle
  task automatic load_setup(input scaler_setup_t s);
    drain_writes();
    write_reg(REG_SOURCE_WIDTH, s.src_w);
    write_reg(REG_WINDOW_X, s.win_x);
    write_reg(REG_WINDOW_Y, s.win_y);
    write_reg(REG_WINDOW_WIDTH, s.win_w);
    write_reg(REG_WINDOW_HEIGHT, s.win_h);
    write_reg(REG_DEST_WIDTH, s.dst_w);
    write_reg(REG_X_FACTOR, s.x_fac);
    write_reg(REG_Y_FACTOR, s.y_fac);
    cfg_we <= 1'b0;
  endtask

  // Mostly small frames whose window overlaps the first lines, with some wide
  // lines, far windows and saturating register values mixed in
  function automatic scaler_setup_t random_setup();
    int sw;
    int eff;
    int wx;
    int wy;
    int ww;
    int wh;
    int dw;
    int xf;
    int yf;
    sw = $urandom_range(12, 1);
    if ($urandom_range(7) == 0) sw = $urandom_range(4095, 0);
    eff = (sw == 0) ? 1 : ((sw > DEF_MAX_DIM) ? DEF_MAX_DIM : sw);
    if (eff <= 16) begin
      wx = $urandom_range(eff - 1, 0);
      ww = $urandom_range(eff + 2, 1);
    end else begin
      wx = $urandom_range(40, 0);
      ww = $urandom_range(16, 1);
    end
    if ($urandom_range(9) == 0) wx = $urandom_range(2047, 0);
    if ($urandom_range(7) == 0) ww = $urandom_range(4095, 2048);
    wy = $urandom_range(2, 0);
    wh = $urandom_range(8, 1);
    if ($urandom_range(11) == 0) wy = $urandom_range(2047, 0);
    if ($urandom_range(7) == 0) wh = $urandom_range(4095, 1);
    dw = $urandom_range(1) ? $urandom_range(40, 0) : $urandom_range(16383, 0);
    xf = $urandom_range(1) ? int'($urandom_range(8, 0)) - 4 : int'($urandom_range(31, 0));
    yf = $urandom_range(1) ? int'($urandom_range(8, 0)) - 4 : int'($urandom_range(31, 0));
    return make_setup(sw, wx, wy, ww, wh, dw, xf, yf);
  endfunction

  // Receiver: honor a long hold-off first, otherwise stall at random
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every result transfer with the oldest predicted write
  always @(posedge clk) begin : compare_writes
    pixel_write_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual addr %h value %h last %b",
                 $time, out_tdata[25:0], out_tdata[33:26], out_tlast);
        fail_count++;
      end else begin
        w = expected_writes.pop_front();
        if (out_tdata[25:0] !== w.addr) begin
          $display("%0t: dest_address mismatch, expected %h, actual %h",
                   $time, w.addr, out_tdata[25:0]);
          fail_count++;
        end
        if (out_tdata[33:26] !== w.value) begin
          $display("%0t: out_value mismatch, expected %h, actual %h",
                   $time, w.value, out_tdata[33:26]);
          fail_count++;
        end
        if (out_tlast !== w.last) begin
          $display("%0t: last_of_run mismatch, expected %b, actual %b",
                   $time, w.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Pixels straight after reset: full 2048 frame, factor one
  task automatic check_reset_defaults();
    send_idle_pct = 0;
    stall_pct     = 0;
    push_pixel(8'h5A, 1'b1);
    push_pixel(8'hA5, 1'b0);
    push_pixel(8'h00, 1'b0);
  endtask

  // Directed corners: extreme factors, saturating and zero registers, windows
  // past the line, decimation skips and empty windows
  task automatic check_corner_cases();
    // Deepest replication: sixteen writes per pixel, second row too
    load_setup(make_setup(2, 0, 0, 2, 2, 5, 4, 4));
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h81, 1'b0);
    // Zero source width acts as one, x factor above the limit saturates,
    // zero y factor acts as one, zero dest width folds every row together;
    // resync with a frame start mid-stream
    load_setup(make_setup(0, 0, 0, 1, 3, 0, 7, 0));
    push_pixel(8'h12, 1'b1);
    push_pixel(8'h34, 1'b0);
    push_pixel(8'h56, 1'b0);
    push_pixel(8'h78, 1'b1);
    // Window past the line end, column and row decimation, a wide stride;
    // covers pixels outside the window and pixels skipped by the phase
    load_setup(make_setup(3, 1, 0, 2048, 2, 8191, -2, -16));
    push_pixel(8'h01, 1'b1);
    repeat (6) push_pixel(8'($urandom_range(255)), 1'b0);
    // Empty windows give no writes at all
    load_setup(make_setup(2, 0, 0, 0, 2, 4, 1, 1));
    push_pixel(8'hC3, 1'b1);
    push_pixel(8'h3C, 1'b0);
    load_setup(make_setup(2, 0, 0, 2, 0, 4, 1, 1));
    push_pixel(8'hE7, 1'b1);
    push_pixel(8'h18, 1'b0);
  endtask

  // Hold off the receiver while pixels keep coming so the queue fills and the
  // input stalls; then pause the sender until every write is out, then send more under random stalls
  task automatic check_backpressure();
    load_setup(make_setup(4, 0, 0, 4, 4, 16, 4, 4));
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 400;
    push_pixel(8'($urandom_range(255)), 1'b1);
    repeat (9) push_pixel(8'($urandom_range(255)), 1'b0);
    drain_writes();
    stall_pct = 19;
    repeat (6) push_pixel(8'($urandom_range(255)), 1'b0);
  endtask

  // Random frames: each setup starts a frame, with occasional stray resyncs
  task automatic check_random_streams(input int idle_pct, input int stall);
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (2) begin
      load_setup(random_setup());
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      push_pixel(8'($urandom_range(255)), 1'b1);
      repeat (45) push_pixel(8'($urandom_range(255)), ($urandom_range(99) < 3));
      send_idle_pct = 0;
      stall_pct     = 0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    check_reset_defaults();
    check_corner_cases();
    check_backpressure();
    check_random_streams(0, 0);
    check_random_streams(63, 0);
    check_random_streams(0, 63);
    check_random_streams(19, 19);
    drain_writes();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop if the stream hangs
  initial begin
    #(CLK_PERIOD * 1000000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
